>>> rtl/ffha_pkg.sv
// Shared constants, types and helpers of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int unsigned HEAP_MAX_BYTES = 65536;
  localparam int unsigned HEADER_BYTES   = 64;
  localparam int unsigned GRANULE_BYTES  = 16;

  localparam int unsigned GRAN_SH  = $clog2(GRANULE_BYTES);
  localparam int unsigned HDR_SPAN =
    ((HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
  localparam int unsigned SLOTS    = HEAP_MAX_BYTES / GRANULE_BYTES;
  localparam int unsigned SLOT_W   = $clog2(SLOTS);
  localparam int unsigned LINK_W   = SLOT_W + 1;

  localparam int unsigned CAP_W = 17;
  localparam int unsigned REQ_W = 32;
  localparam int unsigned OFF_W = 16;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned RND_W = REQ_W + 1;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 136;
  localparam int unsigned OUT_USER_W = 2;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (OFF_W + 3 * CAP_W + 2 * CNT_W);

  localparam logic [LINK_W-1:0] NIL        = LINK_W'(SLOTS);
  localparam logic [CAP_W-1:0]  HDR_C      = CAP_W'(HDR_SPAN);
  localparam logic [CAP_W-1:0]  MIN_SPLIT  = CAP_W'(HDR_SPAN + GRANULE_BYTES);
  localparam logic [CAP_W-1:0]  HEAP_MAX_C = CAP_W'(HEAP_MAX_BYTES);
  localparam logic [CAP_W-1:0]  HEAP_RESET = 17'h10000;

  // One slot of the block table
  typedef struct packed {
    logic              live;
    logic              free;
    logic [CAP_W-1:0]  cap;
    logic [CAP_W-1:0]  used;
    logic [LINK_W-1:0] pphys;
    logic [LINK_W-1:0] nphys;
    logic [LINK_W-1:0] pfree;
    logic [LINK_W-1:0] nfree;
  } entry_t;

  // Access request to the slot table
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
  } tbl_req_t;

  typedef enum logic [0:0] {ALU_ADD, ALU_SUB} alu_op_e;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_MEASURE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOFIT  = 2'd1,
    STS_BADREL = 2'd2,
    STS_NULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {K_NFREE, K_PFREE, K_PPHYS} rmw_kind_e;

  typedef enum logic [4:0] {
    FS_CLEAR, FS_IDLE,
    FS_AL_WALK, FS_AL_FAIL, FS_AL_REM_P, FS_AL_REM_N, FS_AL_SPLIT, FS_AL_PUSH, FS_AL_FIN,
    FS_RL_BAD, FS_RL_CHK, FS_RL_N, FS_RL_NREM_P, FS_RL_NREM_N, FS_RL_NABS,
    FS_RL_PRD, FS_RL_P, FS_RL_PREM_P, FS_RL_PREM_N, FS_RL_PABS, FS_RL_PUSH,
    FS_MS_WALK, FS_RMW_RD, FS_RMW_WR, FS_DONE
  } fsm_e;

  // Pending link update: read slot, patch one field, write back, resume
  typedef struct packed {
    logic [LINK_W-1:0] addr;
    rmw_kind_e         kind;
    logic [LINK_W-1:0] val;
    fsm_e              ret;
  } rmw_t;

  // Clamp to the range, trim to the grid, drop a range too small for one block
  function automatic logic [CAP_W-1:0] usable_of(input logic [CAP_W-1:0] hb);
    logic [CAP_W-1:0] u;
    u = (hb > HEAP_MAX_C) ? HEAP_MAX_C : hb;
    u = u & ~CAP_W'(GRANULE_BYTES - 1);
    if (u < MIN_SPLIT) begin
      u = '0;
    end
    return u;
  endfunction

endpackage
`default_nettype wire

>>> rtl/first_fit_heap_allocator_unit.sv
// First-fit heap allocator with coalescing: sequencer, statistics and stream ports.
// Usage: one command beat enters on the s_axis side (tuser holds the action and the
// null flag, tdata the request size and release offset); one result beat leaves on
// the m_axis side per command (tuser holds the status, tdata the payload offset,
// statistics and largest free capacity). The block takes one command at a time.
// Each command is worked through the slot table and one shared adder: allocate
// walks the free list until a block fits or the list ends; measure walks the
// whole free list; release is refused when the offset is off the heap or the
// grid or when the header check rejects it, and when accepted merges the free
// neighbours, each link update being a read and then a write of one slot.
// The result sits in an output register; a new command is taken while it waits,
// and the sequencer holds in its done step only if a second result is ready
// before the first is taken.
// Reset and every cfg write of heap_bytes rebuild the heap: statistics clear and
// a clearing pass walks all 4096 slots, one per cycle, with s_axis_tready low
// until the pass ends.
`default_nettype none
module first_fit_heap_allocator_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ffha_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // request_bytes[31:0], pointer_offset[47:32]
  input  logic [ffha_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // action[1:0], pointer_is_null[2]
  input  logic [ffha_pkg::IN_USER_W-1:0]      s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // payload_offset[15:0], bytes_in_use[32:16], peak_in_use[49:33],
  // largest_refused[81:50], bad_release_count[113:82], largest_free_bytes[130:114]
  output logic [ffha_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [ffha_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
  import ffha_pkg::*;

  fsm_e              state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic [CAP_W-1:0]  heap_end_q, heap_end_d;
  logic [LINK_W-1:0] free_head_q, free_head_d;
  logic [CAP_W-1:0]  in_use_q, in_use_d, peak_q, peak_d;
  logic [CNT_W-1:0]  refused_q, refused_d, err_q, err_d;
  logic              out_valid_q, out_valid_d;

  logic [REQ_W-1:0]  req_q, req_d;
  logic [RND_W-1:0]  capq_q, capq_d;
  logic [SLOT_W-1:0] s_q, s_d, cur_q, cur_d, t_q, t_d;
  entry_t            ent_q, ent_d, oth_q, oth_d;
  logic [CAP_W-1:0]  diff_q, diff_d, largest_q, largest_d;
  logic              split_q, split_d;
  status_e           status_q, status_d;
  logic [OFF_W-1:0]  payload_q, payload_d;
  rmw_t              rmw_q, rmw_d;

  status_e           out_status_q, out_status_d;
  logic [OFF_W-1:0]  out_payload_q, out_payload_d;
  logic [CAP_W-1:0]  out_in_use_q, out_in_use_d, out_peak_q, out_peak_d;
  logic [CNT_W-1:0]  out_refused_q, out_refused_d, out_err_q, out_err_d;
  logic [CAP_W-1:0]  out_largest_q, out_largest_d;

  tbl_req_t          tbl;
  entry_t            rd;
  alu_op_e           alu_op;
  logic [RND_W-1:0]  alu_a, alu_b;
  logic [RND_W:0]    alu_res;

  logic [REQ_W-1:0]  in_req;
  logic [OFF_W-1:0]  in_off;
  logic [1:0]        in_action;
  logic              in_null;
  logic [RND_W-1:0]  in_want;
  logic              off_bad;
  logic [SLOT_W-1:0] off_slot;
  logic [SLOT_W-1:0] tail_slot;
  logic [CAP_W-1:0]  cfg_usable;
  entry_t            init_ent;

  ffha_slot_table u_table (
    .clk_i     (clk_i),
    .req_i     (tbl),
    .rd_data_o (rd)
  );

  ffha_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Unpack the command beat
  assign in_req    = s_axis_tdata[REQ_W-1:0];
  assign in_off    = s_axis_tdata[REQ_W+OFF_W-1:REQ_W];
  assign in_action = s_axis_tuser[1:0];
  assign in_null   = s_axis_tuser[2];
  assign in_want   = (in_req == '0) ? RND_W'(1) : RND_W'(in_req);

  // Release offset must name a payload on the grid inside the heap
  assign off_bad  = (heap_end_q == '0) || (in_off < OFF_W'(HDR_SPAN)) ||
                    ({1'b0, in_off} >= heap_end_q) || (in_off[GRAN_SH-1:0] != '0);
  assign off_slot = SLOT_W'((in_off - OFF_W'(HDR_SPAN)) >> GRAN_SH);

  // Slot of the split-off tail block
  assign tail_slot = s_q + SLOT_W'((capq_q[CAP_W-1:0] + HDR_C) >> GRAN_SH);

  assign cfg_usable = usable_of(cfg_wdata_i);

  // Whole heap as one free block
  always_comb begin
    init_ent       = '0;
    init_ent.live  = 1'b1;
    init_ent.free  = 1'b1;
    init_ent.cap   = heap_end_q - HDR_C;
    init_ent.pphys = NIL;
    init_ent.nphys = NIL;
    init_ent.pfree = NIL;
    init_ent.nfree = NIL;
  end

  assign s_axis_tready = (state_q == FS_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_largest_q, out_err_q, out_refused_q,
                          out_peak_q, out_in_use_q, out_payload_q};

  // Sequencer: next state, table accesses and adder operands
  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    heap_end_d    = heap_end_q;
    free_head_d   = free_head_q;
    in_use_d      = in_use_q;
    peak_d        = peak_q;
    refused_d     = refused_q;
    err_d         = err_q;
    out_valid_d   = out_valid_q;
    req_d         = req_q;
    capq_d        = capq_q;
    s_d           = s_q;
    cur_d         = cur_q;
    t_d           = t_q;
    ent_d         = ent_q;
    oth_d         = oth_q;
    diff_d        = diff_q;
    largest_d     = largest_q;
    split_d       = split_q;
    status_d      = status_q;
    payload_d     = payload_q;
    rmw_d         = rmw_q;
    out_status_d  = out_status_q;
    out_payload_d = out_payload_q;
    out_in_use_d  = out_in_use_q;
    out_peak_d    = out_peak_q;
    out_refused_d = out_refused_q;
    out_err_d     = out_err_q;
    out_largest_d = out_largest_q;
    tbl           = '0;
    alu_op        = ALU_SUB;
    alu_a         = '0;
    alu_b         = '0;

    // Drop the result once taken
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      FS_CLEAR: begin
        tbl.we      = 1'b1;
        tbl.wr_addr = clr_q;
        tbl.wr_data = ((clr_q == '0) && (heap_end_q != '0)) ? init_ent : '0;
        clr_d       = clr_q + 1'b1;
        if (clr_q == SLOT_W'(SLOTS - 1)) begin
          state_d = FS_IDLE;
        end
      end

      FS_IDLE: begin
        if (s_axis_tvalid) begin
          req_d     = in_req;
          capq_d    = (in_want + RND_W'(GRANULE_BYTES - 1)) & ~RND_W'(GRANULE_BYTES - 1);
          status_d  = STS_OK;
          payload_d = '0;
          largest_d = '0;
          unique case (action_e'(in_action))
            ACT_ALLOC: begin
              if (free_head_q == NIL) begin
                state_d = FS_AL_FAIL;
              end else begin
                tbl.rd_en   = 1'b1;
                tbl.rd_addr = free_head_q[SLOT_W-1:0];
                cur_d       = free_head_q[SLOT_W-1:0];
                state_d     = FS_AL_WALK;
              end
            end
            ACT_RELEASE: begin
              if (in_null) begin
                status_d = STS_NULL;
                state_d  = FS_DONE;
              end else if (off_bad) begin
                state_d = FS_RL_BAD;
              end else begin
                tbl.rd_en   = 1'b1;
                tbl.rd_addr = off_slot;
                s_d         = off_slot;
                state_d     = FS_RL_CHK;
              end
            end
            ACT_MEASURE: begin
              if (free_head_q == NIL) begin
                state_d = FS_DONE;
              end else begin
                tbl.rd_en   = 1'b1;
                tbl.rd_addr = free_head_q[SLOT_W-1:0];
                state_d     = FS_MS_WALK;
              end
            end
            default: begin
              state_d = FS_DONE;
            end
          endcase
        end
      end

      // Walk the free list for the first block that fits
      FS_AL_WALK: begin
        alu_a = RND_W'(rd.cap);
        alu_b = capq_q;
        if (!alu_res[RND_W]) begin
          s_d     = cur_q;
          ent_d   = rd;
          diff_d  = alu_res[CAP_W-1:0];
          state_d = FS_AL_REM_P;
        end else if (rd.nfree == NIL) begin
          state_d = FS_AL_FAIL;
        end else begin
          tbl.rd_en   = 1'b1;
          tbl.rd_addr = rd.nfree[SLOT_W-1:0];
          cur_d       = rd.nfree[SLOT_W-1:0];
        end
      end

      FS_AL_FAIL: begin
        if (req_q > refused_q) begin
          refused_d = req_q;
        end
        status_d = STS_NOFIT;
        state_d  = FS_DONE;
      end

      // Unlink the chosen block
      FS_AL_REM_P: begin
        if (ent_q.pfree == NIL) begin
          free_head_d = ent_q.nfree;
        end
        rmw_d   = '{ent_q.pfree, K_NFREE, ent_q.nfree, FS_AL_REM_N};
        state_d = FS_RMW_RD;
      end

      FS_AL_REM_N: begin
        rmw_d   = '{ent_q.nfree, K_PFREE, ent_q.pfree, FS_AL_SPLIT};
        state_d = FS_RMW_RD;
      end

      // Split off the tail when it can hold a header and one granule
      FS_AL_SPLIT: begin
        if (diff_q >= MIN_SPLIT) begin
          tbl.we            = 1'b1;
          tbl.wr_addr       = tail_slot;
          tbl.wr_data.live  = 1'b1;
          tbl.wr_data.free  = 1'b1;
          tbl.wr_data.cap   = diff_q - HDR_C;
          tbl.wr_data.used  = '0;
          tbl.wr_data.pphys = {1'b0, s_q};
          tbl.wr_data.nphys = ent_q.nphys;
          tbl.wr_data.pfree = NIL;
          tbl.wr_data.nfree = free_head_q;
          t_d               = tail_slot;
          split_d           = 1'b1;
          rmw_d             = '{ent_q.nphys, K_PPHYS, {1'b0, tail_slot}, FS_AL_PUSH};
          state_d           = FS_RMW_RD;
        end else begin
          split_d = 1'b0;
          state_d = FS_AL_FIN;
        end
      end

      FS_AL_PUSH: begin
        free_head_d = {1'b0, t_q};
        rmw_d       = '{free_head_q, K_PFREE, {1'b0, t_q}, FS_AL_FIN};
        state_d     = FS_RMW_RD;
      end

      // Mark the block used and update the totals
      FS_AL_FIN: begin
        tbl.we            = 1'b1;
        tbl.wr_addr       = s_q;
        tbl.wr_data       = ent_q;
        tbl.wr_data.free  = 1'b0;
        tbl.wr_data.used  = req_q[CAP_W-1:0];
        tbl.wr_data.pfree = NIL;
        tbl.wr_data.nfree = NIL;
        if (split_q) begin
          tbl.wr_data.cap   = capq_q[CAP_W-1:0];
          tbl.wr_data.nphys = {1'b0, t_q};
        end
        in_use_d = in_use_q + req_q[CAP_W-1:0];
        if (in_use_d > peak_q) begin
          peak_d = in_use_d;
        end
        payload_d = (OFF_W'(s_q) << GRAN_SH) + OFF_W'(HDR_SPAN);
        state_d   = FS_DONE;
      end

      FS_RL_BAD: begin
        if (err_q != '1) begin
          err_d = err_q + 1'b1;
        end
        status_d = STS_BADREL;
        state_d  = FS_DONE;
      end

      // Check the header, then look at the block after it
      FS_RL_CHK: begin
        if (!rd.live || rd.free) begin
          state_d = FS_RL_BAD;
        end else begin
          ent_d    = rd;
          in_use_d = in_use_q - rd.used;
          if (rd.nphys != NIL) begin
            tbl.rd_en   = 1'b1;
            tbl.rd_addr = rd.nphys[SLOT_W-1:0];
            state_d     = FS_RL_N;
          end else begin
            state_d = FS_RL_PRD;
          end
        end
      end

      FS_RL_N: begin
        if (rd.free) begin
          oth_d   = rd;
          state_d = FS_RL_NREM_P;
        end else begin
          state_d = FS_RL_PRD;
        end
      end

      FS_RL_NREM_P: begin
        if (oth_q.pfree == NIL) begin
          free_head_d = oth_q.nfree;
        end
        rmw_d   = '{oth_q.pfree, K_NFREE, oth_q.nfree, FS_RL_NREM_N};
        state_d = FS_RMW_RD;
      end

      FS_RL_NREM_N: begin
        rmw_d   = '{oth_q.nfree, K_PFREE, oth_q.pfree, FS_RL_NABS};
        state_d = FS_RMW_RD;
      end

      // Absorb the next block
      FS_RL_NABS: begin
        alu_op      = ALU_ADD;
        alu_a       = RND_W'(ent_q.cap);
        alu_b       = RND_W'(oth_q.cap);
        ent_d.cap   = alu_res[CAP_W-1:0] + HDR_C;
        ent_d.nphys = oth_q.nphys;
        tbl.we      = 1'b1;
        tbl.wr_addr = ent_q.nphys[SLOT_W-1:0];
        tbl.wr_data = '0;
        rmw_d       = '{oth_q.nphys, K_PPHYS, {1'b0, s_q}, FS_RL_PRD};
        state_d     = FS_RMW_RD;
      end

      FS_RL_PRD: begin
        if (ent_q.pphys != NIL) begin
          tbl.rd_en   = 1'b1;
          tbl.rd_addr = ent_q.pphys[SLOT_W-1:0];
          state_d     = FS_RL_P;
        end else begin
          state_d = FS_RL_PUSH;
        end
      end

      FS_RL_P: begin
        if (rd.free) begin
          oth_d   = rd;
          state_d = FS_RL_PREM_P;
        end else begin
          state_d = FS_RL_PUSH;
        end
      end

      FS_RL_PREM_P: begin
        if (oth_q.pfree == NIL) begin
          free_head_d = oth_q.nfree;
        end
        rmw_d   = '{oth_q.pfree, K_NFREE, oth_q.nfree, FS_RL_PREM_N};
        state_d = FS_RMW_RD;
      end

      FS_RL_PREM_N: begin
        rmw_d   = '{oth_q.nfree, K_PFREE, oth_q.pfree, FS_RL_PABS};
        state_d = FS_RMW_RD;
      end

      // Fold this block into the previous one, which carries on
      FS_RL_PABS: begin
        alu_op      = ALU_ADD;
        alu_a       = RND_W'(oth_q.cap);
        alu_b       = RND_W'(ent_q.cap);
        ent_d       = oth_q;
        ent_d.cap   = alu_res[CAP_W-1:0] + HDR_C;
        ent_d.nphys = ent_q.nphys;
        s_d         = ent_q.pphys[SLOT_W-1:0];
        tbl.we      = 1'b1;
        tbl.wr_addr = s_q;
        tbl.wr_data = '0;
        rmw_d       = '{ent_q.nphys, K_PPHYS, ent_q.pphys, FS_RL_PUSH};
        state_d     = FS_RMW_RD;
      end

      // Write the free block and push it on the list head
      FS_RL_PUSH: begin
        tbl.we            = 1'b1;
        tbl.wr_addr       = s_q;
        tbl.wr_data       = ent_q;
        tbl.wr_data.live  = 1'b1;
        tbl.wr_data.free  = 1'b1;
        tbl.wr_data.used  = '0;
        tbl.wr_data.pfree = NIL;
        tbl.wr_data.nfree = free_head_q;
        free_head_d       = {1'b0, s_q};
        rmw_d             = '{free_head_q, K_PFREE, {1'b0, s_q}, FS_DONE};
        state_d           = FS_RMW_RD;
      end

      // Track the largest capacity along the free list
      FS_MS_WALK: begin
        alu_a = RND_W'(largest_q);
        alu_b = RND_W'(rd.cap);
        if (alu_res[RND_W]) begin
          largest_d = rd.cap;
        end
        if (rd.nfree == NIL) begin
          state_d = FS_DONE;
        end else begin
          tbl.rd_en   = 1'b1;
          tbl.rd_addr = rd.nfree[SLOT_W-1:0];
        end
      end

      // Patch one link of a slot; a null target is skipped
      FS_RMW_RD: begin
        if (rmw_q.addr == NIL) begin
          state_d = rmw_q.ret;
        end else begin
          tbl.rd_en   = 1'b1;
          tbl.rd_addr = rmw_q.addr[SLOT_W-1:0];
          state_d     = FS_RMW_WR;
        end
      end

      FS_RMW_WR: begin
        tbl.we      = 1'b1;
        tbl.wr_addr = rmw_q.addr[SLOT_W-1:0];
        tbl.wr_data = rd;
        case (rmw_q.kind)
          K_NFREE: tbl.wr_data.nfree = rmw_q.val;
          K_PFREE: tbl.wr_data.pfree = rmw_q.val;
          K_PPHYS: tbl.wr_data.pphys = rmw_q.val;
          default: tbl.wr_data = rd;
        endcase
        state_d = rmw_q.ret;
      end

      // Load the result beat once the output register is free
      FS_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d   = 1'b1;
          out_status_d  = status_q;
          out_payload_d = payload_q;
          out_in_use_d  = in_use_q;
          out_peak_d    = peak_q;
          out_refused_d = refused_q;
          out_err_d     = err_q;
          out_largest_d = largest_q;
          state_d       = FS_IDLE;
        end
      end

      default: begin
        state_d = FS_IDLE;
      end
    endcase

    // Size write rebuilds the heap
    if (cfg_we_i) begin
      heap_end_d  = cfg_usable;
      free_head_d = (cfg_usable == '0) ? NIL : '0;
      in_use_d    = '0;
      peak_d      = '0;
      refused_d   = '0;
      err_d       = '0;
      clr_d       = '0;
      state_d     = FS_CLEAR;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_CLEAR;
      clr_q       <= '0;
      heap_end_q  <= usable_of(HEAP_RESET);
      free_head_q <= (usable_of(HEAP_RESET) == '0) ? NIL : '0;
      in_use_q    <= '0;
      peak_q      <= '0;
      refused_q   <= '0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      heap_end_q  <= heap_end_d;
      free_head_q <= free_head_d;
      in_use_q    <= in_use_d;
      peak_q      <= peak_d;
      refused_q   <= refused_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    req_q         <= req_d;
    capq_q        <= capq_d;
    s_q           <= s_d;
    cur_q         <= cur_d;
    t_q           <= t_d;
    ent_q         <= ent_d;
    oth_q         <= oth_d;
    diff_q        <= diff_d;
    largest_q     <= largest_d;
    split_q       <= split_d;
    status_q      <= status_d;
    payload_q     <= payload_d;
    rmw_q         <= rmw_d;
    out_status_q  <= out_status_d;
    out_payload_q <= out_payload_d;
    out_in_use_q  <= out_in_use_d;
    out_peak_q    <= out_peak_d;
    out_refused_q <= out_refused_d;
    out_err_q     <= out_err_d;
    out_largest_q <= out_largest_d;
  end

endmodule
`default_nettype wire

>>> rtl/ffha_alu.sv
// Shared add/subtract unit of the allocator sequencer.
`default_nettype none
module ffha_alu (
  input  ffha_pkg::alu_op_e               op_i,
  input  logic [ffha_pkg::RND_W-1:0]      a_i,
  input  logic [ffha_pkg::RND_W-1:0]      b_i,
  output logic [ffha_pkg::RND_W:0]        res_o
);
  import ffha_pkg::*;

  // Top bit is the borrow on subtract
  assign res_o = (op_i == ALU_SUB) ? ({1'b0, a_i} - {1'b0, b_i})
                                   : ({1'b0, a_i} + {1'b0, b_i});

endmodule
`default_nettype wire

>>> rtl/ffha_slot_table.sv
// Block slot table: one write port, one registered read port.
`default_nettype none
module ffha_slot_table (
  input  logic               clk_i,
  input  ffha_pkg::tbl_req_t req_i,
  output ffha_pkg::entry_t   rd_data_o
);
  import ffha_pkg::*;

  entry_t mem_q [SLOTS];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb_first_fit_heap_allocator_unit.sv
// Self-checking testbench of the first-fit heap allocator unit with a shadow heap model.
module tb_first_fit_heap_allocator_unit;
  import ffha_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 4_000_000;
  localparam int unsigned GR = 16;
  localparam int unsigned HS = 64;
  localparam int unsigned NSLOT = 4096;
  localparam logic [12:0] NIL_LINK = 13'd4096;

  typedef logic [12:0] link_t;

  typedef struct {
    status_e     status;
    logic [15:0] payload;
    logic [16:0] in_use;
    logic [16:0] peak;
    logic [31:0] refused;
    logic [31:0] bad_count;
    logic [16:0] largest_free;
  } heap_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CAP_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [IN_USER_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  first_fit_heap_allocator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap
  bit          blk_live [NSLOT];
  bit          blk_free [NSLOT];
  logic [16:0] blk_cap [NSLOT];
  logic [31:0] blk_used [NSLOT];
  link_t       blk_pphys [NSLOT];
  link_t       blk_nphys [NSLOT];
  link_t       blk_pfree [NSLOT];
  link_t       blk_nfree [NSLOT];
  link_t       head_free;
  logic [31:0] heap_limit;
  logic [31:0] total_in_use, peak_in_use, max_refused, bad_releases;

  heap_result_t expected_results[$];
  logic [15:0] live_payloads[$];
  logic [15:0] freed_payloads[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit idle_on = 1'b1;

  // Rebuild the shadow heap as one free block
  task automatic heap_rebuild(input logic [16:0] size_bytes);
    int unsigned usable;
    usable = (size_bytes > 17'd65536) ? 65536 : size_bytes;
    usable -= usable % GR;
    for (int i = 0; i < NSLOT; i++) begin
      blk_live[i] = 0; blk_free[i] = 0; blk_cap[i] = '0; blk_used[i] = '0;
      blk_pphys[i] = '0; blk_nphys[i] = '0; blk_pfree[i] = '0; blk_nfree[i] = '0;
    end
    total_in_use = '0; peak_in_use = '0; max_refused = '0; bad_releases = '0;
    head_free = NIL_LINK;
    heap_limit = '0;
    live_payloads.delete();
    freed_payloads.delete();
    if (usable >= HS + GR) begin
      heap_limit = usable;
      blk_live[0] = 1; blk_free[0] = 1;
      blk_cap[0] = 17'(usable - HS);
      blk_pphys[0] = NIL_LINK; blk_nphys[0] = NIL_LINK;
      blk_pfree[0] = NIL_LINK; blk_nfree[0] = NIL_LINK;
      head_free = '0;
    end
  endtask

  task automatic free_unlink(input link_t s);
    link_t p, n;
    p = blk_pfree[s];
    n = blk_nfree[s];
    if (p < NIL_LINK) blk_nfree[p] = n;
    else head_free = n;
    if (n < NIL_LINK) blk_pfree[n] = p;
    blk_pfree[s] = NIL_LINK;
    blk_nfree[s] = NIL_LINK;
  endtask

  task automatic free_push(input link_t s);
    blk_pfree[s] = NIL_LINK;
    blk_nfree[s] = head_free;
    if (head_free < NIL_LINK) blk_pfree[head_free] = s;
    head_free = s;
  endtask

  // Merge physical successor n into s
  task automatic merge_into(input link_t s, input link_t n);
    link_t after;
    after = blk_nphys[n];
    blk_cap[s] = blk_cap[s] + 17'(HS) + blk_cap[n];
    blk_nphys[s] = after;
    if (after < NIL_LINK) blk_pphys[after] = s;
    blk_live[n] = 0;
    blk_free[n] = 0;
  endtask

  function automatic link_t owner_of(input logic [15:0] off);
    link_t s, nb;
    if (heap_limit == 0 || off < HS || off >= heap_limit) return NIL_LINK;
    if ((off - HS) % GR != 0) return NIL_LINK;
    s = link_t'((off - HS) / GR);
    if (!blk_live[s]) return NIL_LINK;
    nb = blk_pphys[s];
    if (nb >= NIL_LINK) begin
      if (s != 0) return NIL_LINK;
    end else if (blk_nphys[nb] != s) begin
      return NIL_LINK;
    end
    nb = blk_nphys[s];
    if (nb < NIL_LINK && blk_pphys[nb] != s) return NIL_LINK;
    return s;
  endfunction

  // Apply one command to the shadow heap and produce its result
  task automatic heap_apply(input action_e act, input logic [31:0] req, input logic [15:0] off,
                            input logic nul, output heap_result_t r);
    longint unsigned need;
    link_t s, t, nx, n, p;
    int unsigned steps;
    logic [16:0] best;
    r.status = STS_OK;
    r.payload = '0;
    best = '0;
    case (act)
      ACT_ALLOC: begin
        need = (req == 0) ? 1 : req;
        need = ((need + GR - 1) / GR) * GR;
        s = head_free;
        steps = 0;
        while (s < NIL_LINK && steps < NSLOT && longint'(blk_cap[s]) < need) begin
          s = blk_nfree[s];
          steps++;
        end
        if (s >= NIL_LINK || longint'(blk_cap[s]) < need) begin
          if (req > max_refused) max_refused = req;
          r.status = STS_NOFIT;
        end else begin
          free_unlink(s);
          // split off the tail when it holds a header plus one granule
          if (blk_cap[s] - need >= HS + GR) begin
            t = link_t'((s * GR + HS + need) / GR);
            blk_live[t] = 1; blk_free[t] = 1;
            blk_cap[t] = 17'(blk_cap[s] - need - HS);
            blk_used[t] = '0;
            nx = blk_nphys[s];
            blk_pphys[t] = s;
            blk_nphys[t] = nx;
            if (nx < NIL_LINK) blk_pphys[nx] = t;
            blk_nphys[s] = t;
            blk_cap[s] = 17'(need);
            free_push(t);
          end
          blk_free[s] = 0;
          blk_used[s] = req;
          total_in_use += req;
          if (total_in_use > peak_in_use) peak_in_use = total_in_use;
          r.payload = 16'(s * GR + HS);
        end
      end
      ACT_RELEASE: begin
        if (nul) begin
          r.status = STS_NULL;
        end else begin
          s = owner_of(off);
          if (s >= NIL_LINK || blk_free[s]) begin
            if (bad_releases != 32'hFFFF_FFFF) bad_releases++;
            r.status = STS_BADREL;
          end else begin
            total_in_use -= blk_used[s];
            blk_used[s] = '0;
            blk_free[s] = 1;
            n = blk_nphys[s];
            if (n < NIL_LINK && blk_free[n]) begin
              free_unlink(n);
              merge_into(s, n);
            end
            p = blk_pphys[s];
            if (p < NIL_LINK && blk_free[p]) begin
              free_unlink(p);
              merge_into(p, s);
              s = p;
            end
            free_push(s);
          end
        end
      end
      ACT_MEASURE: begin
        s = head_free;
        steps = 0;
        while (s < NIL_LINK && steps < NSLOT) begin
          if (blk_cap[s] > best) best = blk_cap[s];
          s = blk_nfree[s];
          steps++;
        end
      end
      default: ;
    endcase
    r.in_use = total_in_use[16:0];
    r.peak = peak_in_use[16:0];
    r.refused = max_refused;
    r.bad_count = bad_releases;
    r.largest_free = best;
  endtask

  // Send one command beat and record its expected result
  task automatic send_cmd(input action_e act, input logic [31:0] req, input logic [15:0] off,
                          input logic nul);
    heap_result_t r;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {off, req};
    s_axis_tuser <= {nul, act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    heap_apply(act, req, off, nul, r);
    expected_results.push_back(r);
    if (act == ACT_ALLOC && r.status == STS_OK) live_payloads.push_back(r.payload);
  endtask

  task automatic alloc_bytes(input logic [31:0] req);
    send_cmd(ACT_ALLOC, req, 16'($urandom), 1'($urandom));
  endtask

  task automatic release_at(input logic [15:0] off);
    foreach (live_payloads[i]) begin
      if (live_payloads[i] == off) begin
        live_payloads.delete(i);
        freed_payloads.push_back(off);
        break;
      end
    end
    send_cmd(ACT_RELEASE, $urandom, off, 1'b0);
  endtask

  task automatic measure_free();
    send_cmd(ACT_MEASURE, $urandom, 16'($urandom), 1'($urandom));
  endtask

  // Drain, then write the heap size while the block is idle
  task automatic set_heap_size(input logic [16:0] size_bytes);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= size_bytes;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heap_rebuild(size_bytes);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h, want 0x%0h at cycle %0d", field, got, want, cycle_count);
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk_i) begin
    heap_result_t w;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'(m_axis_tuser), 0);
      end else begin
        w = expected_results.pop_front();
        if (m_axis_tuser != w.status) report_mismatch("status", 32'(m_axis_tuser), 32'(w.status));
        if (m_axis_tdata[15:0] != w.payload)
          report_mismatch("payload_offset", 32'(m_axis_tdata[15:0]), 32'(w.payload));
        if (m_axis_tdata[32:16] != w.in_use)
          report_mismatch("bytes_in_use", 32'(m_axis_tdata[32:16]), 32'(w.in_use));
        if (m_axis_tdata[49:33] != w.peak)
          report_mismatch("peak_in_use", 32'(m_axis_tdata[49:33]), 32'(w.peak));
        if (m_axis_tdata[81:50] != w.refused)
          report_mismatch("largest_refused", m_axis_tdata[81:50], w.refused);
        if (m_axis_tdata[113:82] != w.bad_count)
          report_mismatch("bad_release_count", m_axis_tdata[113:82], w.bad_count);
        if (m_axis_tdata[130:114] != w.largest_free)
          report_mismatch("largest_free_bytes", 32'(m_axis_tdata[130:114]), 32'(w.largest_free));
      end
    end
  end

  // Stall the result side in random bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** first_fit_heap_allocator_unit: FAILED **");
      $finish;
    end
  end

  // Field extremes, every action and the corner cases on the full heap
  task automatic test_directed();
    logic [15:0] a, b, c;
    alloc_bytes(0);
    alloc_bytes(1);
    alloc_bytes(16);
    alloc_bytes(17);
    a = live_payloads[0]; b = live_payloads[1]; c = live_payloads[2];
    release_at(a);
    release_at(c);
    release_at(b);
    release_at(b);
    send_cmd(ACT_RELEASE, '0, 16'd200, 1'b1);
    send_cmd(ACT_RELEASE, '0, 16'd0, 1'b0);
    send_cmd(ACT_RELEASE, '1, 16'hFFFF, 1'b0);
    send_cmd(ACT_RELEASE, '0, 16'd65, 1'b0);
    send_cmd(ACT_RELEASE, '0, 16'd64 + 16'd160, 1'b0);
    measure_free();
    send_cmd(ACT_NONE, '1, '1, 1'b1);
    alloc_bytes(32'hFFFF_FFFF);
    release_at(live_payloads[0]);
    alloc_bytes(32'd65472);
    measure_free();
    release_at(live_payloads[0]);
    alloc_bytes(32'd65473);
    measure_free();
  endtask

  // Smallest heap, one-granule block, heaps too small to hold one, and an oversized heap
  task automatic test_size_extremes();
    set_heap_size(17'd80);
    alloc_bytes(16);
    alloc_bytes(1);
    measure_free();
    release_at(live_payloads[0]);
    measure_free();
    set_heap_size(17'd79);
    alloc_bytes(0);
    send_cmd(ACT_RELEASE, '0, 16'd64, 1'b0);
    measure_free();
    set_heap_size(17'd0);
    alloc_bytes(1);
    send_cmd(ACT_RELEASE, '0, 16'd64, 1'b0);
    measure_free();
    set_heap_size(17'h1FFFF);
    alloc_bytes(32'd65472);
    measure_free();
  endtask

  // Random allocate and release traffic with some noise
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned max_req);
    int unsigned pick, idx;
    logic [31:0] req;
    for (int unsigned k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (live_payloads.size() > 40 && pick < 45) pick += 45;
      if (pick < 45) begin
        case ($urandom_range(0, 19))
          0: req = $urandom;
          1, 2, 3, 4: req = $urandom_range(0, max_req);
          default: req = $urandom_range(0, max_req / 8);
        endcase
        alloc_bytes(req);
      end else if (pick < 82 && live_payloads.size() != 0) begin
        idx = $urandom_range(0, live_payloads.size() - 1);
        release_at(live_payloads[idx]);
      end else if (pick < 86 && freed_payloads.size() != 0) begin
        release_at(freed_payloads[$urandom_range(0, freed_payloads.size() - 1)]);
      end else if (pick < 89) begin
        send_cmd(ACT_RELEASE, $urandom, 16'($urandom), 1'b0);
      end else if (pick < 92) begin
        send_cmd(ACT_RELEASE, $urandom, 16'($urandom), 1'b1);
      end else if (pick < 98) begin
        measure_free();
      end else begin
        send_cmd(ACT_NONE, $urandom, 16'($urandom), 1'($urandom));
      end
      if (freed_payloads.size() > 32) void'(freed_payloads.pop_front());
    end
  endtask

  initial begin
    heap_rebuild(17'h10000);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_size_extremes();
    set_heap_size(17'd1000);
    test_random_traffic(250, 600);
    set_heap_size(17'd65536);
    test_random_traffic(400, 3000);
    set_heap_size(17'd4095);
    test_random_traffic(250, 1200);
    set_heap_size(17'd65536);
    idle_on = 1'b0;
    test_random_traffic(200, 2000);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** first_fit_heap_allocator_unit: PASSED **");
    end else begin
      $display("** first_fit_heap_allocator_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> first_fit_heap_allocator_unit.f
rtl/ffha_pkg.sv
rtl/ffha_alu.sv
rtl/ffha_slot_table.sv
rtl/first_fit_heap_allocator_unit.sv
tb/sv/tb_first_fit_heap_allocator_unit.sv
